// ===== rtl/srrw_pkg.sv =====
// Package: shared types and constants of the selective-repeat receive window.
`default_nettype none
package srrw_pkg;
  localparam int unsigned SEQ_TOP = 15;

  typedef enum logic [2:0] {
    ACT_DATA    = 3'd0,
    ACT_OTHER   = 3'd1,
    ACT_TICK    = 3'd2,
    ACT_POLL    = 3'd3,
    ACT_RELEASE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ACK_NORMAL  = 2'd0,
    ACK_NOSPACE = 2'd1,
    ACK_REFRESH = 2'd2
  } ack_kind_t;

  typedef enum logic [2:0] {
    OUT_INORDER   = 3'd0,
    OUT_PLACED    = 3'd1,
    OUT_DUPLICATE = 3'd2,
    OUT_OUTSIDE   = 3'd3,
    OUT_IGNORED   = 3'd4,
    OUT_DELIVERED = 3'd5,
    OUT_NOTHING   = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD,
    ST_SCAN,
    ST_RELEASE,
    ST_OUT
  } state_t;

  localparam logic [1:0] REG_WINDOW_MAX    = 2'd0;
  localparam logic [1:0] REG_SILENCE_LIMIT = 2'd1;
  localparam logic [1:0] REG_PEER_IP       = 2'd2;
  localparam logic [1:0] REG_PEER_PORT     = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic decide;    // act on captured beat (everything but scan)
    logic scan;      // examine one slot of the forward scan
    logic scan_end;  // finish forward scan
    logic rd;        // issue payload read for release
    logic fin_rel;   // latch released payload
    logic out_load;  // present result (never raised; ST_OUT drives out_valid)
  } cmd_t;

  typedef struct packed {
    logic need_scan;  // in-order arrival
    logic need_rel;   // release with held data
    logic scan_done;  // scan stops this cycle
  } sts_t;

  function automatic logic [3:0] seq_next(input logic [3:0] s);
    return (s >= 4'(SEQ_TOP)) ? 4'd1 : s + 4'd1;
  endfunction

  function automatic logic [3:0] seq_prev(input logic [3:0] s);
    return (s <= 4'd1) ? 4'(SEQ_TOP) : s - 4'd1;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/srrw_if.sv =====
// Interfaces: valid/ready channels for input beats and result beats.
`default_nettype none
interface srrw_in_if #(parameter int PAYLOAD_BITS = 32);
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic [3:0]              seq_no;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [31:0]             src_ip;
  logic [15:0]             src_port;
  logic                    dropped;
  modport source (output valid, action, seq_no, payload, src_ip, src_port, dropped,
                  input ready);
  modport sink (input valid, action, seq_no, payload, src_ip, src_port, dropped,
                output ready);
endinterface

interface srrw_out_if #(parameter int PAYLOAD_BITS = 32);
  logic                    valid;
  logic                    ready;
  logic                    ack_valid;
  logic [1:0]              ack_kind;
  logic [3:0]              ack_seq;
  logic [3:0]              ack_window;
  logic [2:0]              outcome;
  logic                    deliver_valid;
  logic [PAYLOAD_BITS-1:0] deliver_payload;
  modport source (output valid, ack_valid, ack_kind, ack_seq, ack_window, outcome,
                  deliver_valid, deliver_payload, input ready);
  modport sink (input valid, ack_valid, ack_kind, ack_seq, ack_window, outcome,
                deliver_valid, deliver_payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/srrw_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module srrw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/srrw_ctrl.sv =====
// Controller: sequences capture, decision, scan, release and result beat.
`default_nettype none
module srrw_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire srrw_pkg::sts_t sts,
  output srrw_pkg::cmd_t      cmd
);
  srrw_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srrw_pkg::ST_IDLE:    if (in_valid) state_nxt = srrw_pkg::ST_DECIDE;
      srrw_pkg::ST_DECIDE: begin
        if (sts.need_scan)     state_nxt = srrw_pkg::ST_SCAN;
        else if (sts.need_rel) state_nxt = srrw_pkg::ST_RD;
        else                   state_nxt = srrw_pkg::ST_OUT;
      end
      srrw_pkg::ST_SCAN:    if (sts.scan_done) state_nxt = srrw_pkg::ST_OUT;
      srrw_pkg::ST_RD:      state_nxt = srrw_pkg::ST_RELEASE;
      srrw_pkg::ST_RELEASE: state_nxt = srrw_pkg::ST_OUT;
      srrw_pkg::ST_OUT:     if (out_ready) state_nxt = srrw_pkg::ST_IDLE;
      default:              state_nxt = srrw_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      srrw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      srrw_pkg::ST_DECIDE:  cmd.decide = 1'b1;
      srrw_pkg::ST_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.scan_end = sts.scan_done;
      end
      srrw_pkg::ST_RD:      cmd.rd = 1'b1;
      srrw_pkg::ST_RELEASE: cmd.fin_rel = 1'b1;
      srrw_pkg::ST_OUT:     out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srrw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/srrw_dp.sv =====
// Datapath: window state, slot tags, payload RAM and result registers.
`default_nettype none
module srrw_dp #(
  parameter int RECV_SLOTS   = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire srrw_pkg::cmd_t          cmd,
  output srrw_pkg::sts_t               sts,
  input  wire logic [2:0]              in_action,
  input  wire logic [3:0]              in_seq_no,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload,
  input  wire logic [31:0]             in_src_ip,
  input  wire logic [15:0]             in_src_port,
  input  wire logic                    in_dropped,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_idx,
  input  wire logic [31:0]             cfg_wdata,
  output logic [31:0]                  cfg_rdata,
  input  wire logic [1:0]              cfg_ridx,
  output logic                         ack_valid,
  output logic [1:0]                   ack_kind,
  output logic [3:0]                   ack_seq,
  output logic [3:0]                   ack_window,
  output logic [2:0]                   outcome,
  output logic                         deliver_valid,
  output logic [PAYLOAD_BITS-1:0]      deliver_payload
);
  localparam int PW = $clog2(RECV_SLOTS);

  // Configuration
  logic [3:0]  window_max_r;
  logic [7:0]  silence_limit_r;
  logic [31:0] peer_ip_r;
  logic [15:0] peer_port_r;

  // Window state
  logic [3:0]  slot_seq_r [RECV_SLOTS];
  logic [3:0]  expected_seq_r;
  logic [PW-1:0] write_pos_r, read_pos_r;
  logic [3:0]  held_count_r;
  logic [3:0]  window_free_r;
  logic        no_space_r;
  logic [7:0]  silent_ticks_r;

  // Captured beat
  logic [2:0]              act_r;
  logic [3:0]              seq_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [31:0]             sip_r;
  logic [15:0]             sport_r;
  logic                    drop_r;

  // Scan state
  logic [PW-1:0] scan_idx_r;
  logic [PW:0]   scan_k_r;
  logic [3:0]    last_r;
  logic [4:0]    moved_r;

  // Result registers
  logic                    ack_valid_r;
  logic [1:0]              ack_kind_r;
  logic [3:0]              ack_seq_r;
  logic [3:0]              ack_window_r;
  logic [2:0]              outcome_r;
  logic                    deliver_valid_r;
  logic [PAYLOAD_BITS-1:0] deliver_payload_r;

  // RAM
  logic                    ram_we;
  logic [PW-1:0]           ram_waddr;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  srrw_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(RECV_SLOTS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(pay_r),
    .raddr(read_pos_r),
    .rdata(ram_rdata)
  );

  // Decision helpers
  logic       is_msg, accepted_src, in_order;
  logic [7:0] ticks_inc;
  logic [3:0] prev_exp;
  logic [3:0] offset;      // seq distance from expected, mod 15
  logic [4:0] diff;
  logic       in_window;
  logic [PW-1:0] place_idx;
  logic [3:0] wf_dec;

  always_comb begin
    is_msg       = (act_r == srrw_pkg::ACT_DATA) || (act_r == srrw_pkg::ACT_OTHER);
    accepted_src = (sip_r == peer_ip_r) && (sport_r == peer_port_r) &&
                   (act_r == srrw_pkg::ACT_DATA);
    in_order     = (seq_r == expected_seq_r);
    ticks_inc    = (silent_ticks_r == 8'hFF) ? silent_ticks_r : silent_ticks_r + 8'd1;
    prev_exp     = srrw_pkg::seq_prev(expected_seq_r);
    diff         = {1'b0, seq_r} + 5'd15 - {1'b0, expected_seq_r};
    offset       = (diff >= 5'd15) ? 4'(diff - 5'd15) : diff[3:0];
    in_window    = (seq_r != 4'd0) && ({1'b0, offset} < {1'b0, window_free_r});
    place_idx    = PW'(({1'b0, write_pos_r} + 5'(offset)) % RECV_SLOTS);
    wf_dec       = (window_free_r != 4'd0) ? window_free_r - 4'd1 : 4'd0;
  end

  // Scan step
  logic [PW-1:0] scan_nidx;
  logic          scan_hit;
  always_comb begin
    scan_nidx = PW'(({1'b0, scan_idx_r} + 1'b1) % RECV_SLOTS);
    scan_hit  = (scan_k_r < (PW+1)'(RECV_SLOTS)) && (slot_seq_r[scan_idx_r] != 4'd0) &&
                (slot_seq_r[scan_idx_r] == srrw_pkg::seq_next(last_r));
    sts.need_scan = cmd.decide && is_msg && !no_space_r && !drop_r && accepted_src &&
                    in_order;
    sts.need_rel  = cmd.decide && (act_r == srrw_pkg::ACT_RELEASE) &&
                    (held_count_r != 4'd0);
    sts.scan_done = !scan_hit;
  end

  assign ram_we    = cmd.decide && is_msg && !no_space_r && !drop_r && accepted_src &&
                     (in_order || (in_window && slot_seq_r[place_idx] != seq_r));
  assign ram_waddr = in_order ? write_pos_r : place_idx;

  // Config readback
  always_comb begin
    unique case (cfg_ridx)
      srrw_pkg::REG_WINDOW_MAX:    cfg_rdata = {28'd0, window_max_r};
      srrw_pkg::REG_SILENCE_LIMIT: cfg_rdata = {24'd0, silence_limit_r};
      srrw_pkg::REG_PEER_IP:       cfg_rdata = peer_ip_r;
      srrw_pkg::REG_PEER_PORT:     cfg_rdata = {16'd0, peer_port_r};
      default:                     cfg_rdata = '0;
    endcase
  end

  // Main state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_max_r    <= 4'd5;
      silence_limit_r <= 8'd3;
      peer_ip_r       <= '0;
      peer_port_r     <= '0;
      for (int i = 0; i < RECV_SLOTS; i++) slot_seq_r[i] <= '0;
      expected_seq_r  <= 4'd1;
      write_pos_r     <= '0;
      read_pos_r      <= '0;
      held_count_r    <= '0;
      window_free_r   <= 4'd5;
      no_space_r      <= 1'b0;
      silent_ticks_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          srrw_pkg::REG_WINDOW_MAX:    window_max_r    <= cfg_wdata[3:0];
          srrw_pkg::REG_SILENCE_LIMIT: silence_limit_r <= cfg_wdata[7:0];
          srrw_pkg::REG_PEER_IP:       peer_ip_r       <= cfg_wdata;
          srrw_pkg::REG_PEER_PORT:     peer_port_r     <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      // Decide: tick, poll and release updates and the first half of arrivals
      if (cmd.decide) begin
        if (is_msg) begin
          if (!no_space_r) begin
            if (drop_r) begin
              silent_ticks_r <= (ticks_inc >= silence_limit_r) ? 8'd0 : ticks_inc;
            end else begin
              silent_ticks_r <= '0;
              if (accepted_src && (in_order ||
                  (in_window && slot_seq_r[place_idx] != seq_r))) begin
                slot_seq_r[ram_waddr] <= seq_r;
                window_free_r <= wf_dec;
                if (wf_dec == 4'd0) no_space_r <= 1'b1;
              end
            end
          end
        end else if (act_r == srrw_pkg::ACT_TICK) begin
          if (no_space_r && window_free_r != 4'd0) begin
            silent_ticks_r <= ticks_inc;
            no_space_r     <= 1'b0;
          end else begin
            silent_ticks_r <= (ticks_inc >= silence_limit_r) ? 8'd0 : ticks_inc;
          end
        end else if (act_r == srrw_pkg::ACT_POLL) begin
          silent_ticks_r <= (ticks_inc >= silence_limit_r) ? 8'd0 : ticks_inc;
        end else if (act_r == srrw_pkg::ACT_RELEASE && held_count_r != 4'd0) begin
          slot_seq_r[read_pos_r] <= '0;
          held_count_r <= held_count_r - 4'd1;
          if (window_free_r < window_max_r) window_free_r <= window_free_r + 4'd1;
        end
      end
      // Advance the read slot once its payload has been latched
      if (cmd.fin_rel) begin
        read_pos_r <= PW'(({1'b0, read_pos_r} + 1'b1) % RECV_SLOTS);
      end
      // Finish scan: commit write slot, expected number and held count
      if (cmd.scan_end) begin
        write_pos_r    <= scan_idx_r;
        expected_seq_r <= srrw_pkg::seq_next(last_r);
        held_count_r   <= ({1'b0, held_count_r} + moved_r > 5'd15) ? 4'd15 :
                          4'(held_count_r + moved_r[3:0]);
      end
    end
  end

  // Capture, scan registers and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      seq_r   <= in_seq_no;
      pay_r   <= in_payload;
      sip_r   <= in_src_ip;
      sport_r <= in_src_port;
      drop_r  <= in_dropped;
    end
    if (cmd.decide) begin
      scan_idx_r <= PW'(({1'b0, write_pos_r} + 1'b1) % RECV_SLOTS);
      scan_k_r   <= (PW+1)'(1);
      last_r     <= seq_r;
      moved_r    <= 5'd1;
      ack_valid_r       <= 1'b0;
      ack_kind_r        <= '0;
      ack_seq_r         <= '0;
      ack_window_r      <= '0;
      outcome_r         <= srrw_pkg::OUT_NOTHING;
      deliver_valid_r   <= 1'b0;
      deliver_payload_r <= '0;
      if (is_msg) begin
        outcome_r <= srrw_pkg::OUT_IGNORED;
        if (!no_space_r) begin
          if (drop_r) begin
            if (ticks_inc >= silence_limit_r) begin
              ack_valid_r  <= 1'b1;
              ack_kind_r   <= srrw_pkg::ACK_REFRESH;
              ack_seq_r    <= prev_exp;
              ack_window_r <= window_free_r;
            end
          end else if (accepted_src) begin
            ack_valid_r <= 1'b1;
            ack_kind_r  <= srrw_pkg::ACK_NORMAL;
            if (in_order) begin
              outcome_r    <= srrw_pkg::OUT_INORDER;
              ack_window_r <= wf_dec;
            end else begin
              ack_seq_r <= prev_exp;
              if (!in_window) begin
                outcome_r    <= srrw_pkg::OUT_OUTSIDE;
                ack_window_r <= window_free_r;
              end else if (slot_seq_r[place_idx] != seq_r) begin
                outcome_r    <= srrw_pkg::OUT_PLACED;
                ack_window_r <= wf_dec;
              end else begin
                outcome_r    <= srrw_pkg::OUT_DUPLICATE;
                ack_window_r <= window_free_r;
              end
            end
          end
        end
      end else if (act_r == srrw_pkg::ACT_TICK || act_r == srrw_pkg::ACT_POLL) begin
        if (act_r == srrw_pkg::ACT_TICK && no_space_r && window_free_r != 4'd0) begin
          ack_valid_r  <= 1'b1;
          ack_kind_r   <= srrw_pkg::ACK_NOSPACE;
          ack_seq_r    <= prev_exp;
          ack_window_r <= window_free_r;
        end else if (ticks_inc >= silence_limit_r) begin
          ack_valid_r  <= 1'b1;
          ack_kind_r   <= srrw_pkg::ACK_REFRESH;
          ack_seq_r    <= prev_exp;
          ack_window_r <= window_free_r;
        end
      end else if (act_r == srrw_pkg::ACT_RELEASE && held_count_r != 4'd0) begin
        outcome_r       <= srrw_pkg::OUT_DELIVERED;
        deliver_valid_r <= 1'b1;
      end
    end
    // One slot per cycle of the forward scan
    if (cmd.scan) begin
      if (scan_hit) begin
        last_r     <= srrw_pkg::seq_next(last_r);
        moved_r    <= moved_r + 5'd1;
        scan_idx_r <= scan_nidx;
        scan_k_r   <= scan_k_r + 1'b1;
      end else begin
        ack_seq_r <= last_r;
      end
    end
    if (cmd.fin_rel) begin
      deliver_payload_r <= ram_rdata;
    end
  end

  assign ack_valid       = ack_valid_r;
  assign ack_kind        = ack_kind_r;
  assign ack_seq         = ack_seq_r;
  assign ack_window      = ack_window_r;
  assign outcome         = outcome_r;
  assign deliver_valid   = deliver_valid_r;
  assign deliver_payload = deliver_payload_r;
endmodule
`default_nettype wire

// ===== rtl/selective_repeat_receive_window_core.sv =====
// Top level: selective-repeat receive window with APB-style configuration.
//
// Usage: one input channel carries messages, ticks, polls and releases; each
// accepted input beat yields exactly one result beat on the output channel.
// Configuration goes through an APB-style port (window_max at 0x0,
// silence_limit at 0x4, peer_ip at 0x8, peer_port at 0xC); the user must
// write it only while the block is idle, which the block does not enforce.
// Sequencing: one item at a time. A plain item's result beat follows the
// decide state; a release first reads its payload from the RAM (read and
// latch states); an in-order arrival first runs the forward scan, which
// examines one slot tag per cycle, 1 to RECV_SLOTS slots. in_ready
// returns the cycle after the result beat is taken.
// Reset (rst_n low, synchronous) empties every slot, restores the
// registers to their defaults and sets the free window to 5.
// A stalled output holds the result beat and keeps in_ready low.
`default_nettype none
module selective_repeat_receive_window_core #(
  parameter int RECV_SLOTS   = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  srrw_in_if.sink          in_ch,
  srrw_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  srrw_pkg::cmd_t cmd;
  srrw_pkg::sts_t sts;
  logic           cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  srrw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srrw_dp #(.RECV_SLOTS(RECV_SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_ch.action),
    .in_seq_no      (in_ch.seq_no),
    .in_payload     (in_ch.payload),
    .in_src_ip      (in_ch.src_ip),
    .in_src_port    (in_ch.src_port),
    .in_dropped     (in_ch.dropped),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_paddr[3:2]),
    .cfg_wdata      (cfg_pwdata),
    .cfg_rdata      (cfg_prdata),
    .cfg_ridx       (cfg_paddr[3:2]),
    .ack_valid      (out_ch.ack_valid),
    .ack_kind       (out_ch.ack_kind),
    .ack_seq        (out_ch.ack_seq),
    .ack_window     (out_ch.ack_window),
    .outcome        (out_ch.outcome),
    .deliver_valid  (out_ch.deliver_valid),
    .deliver_payload(out_ch.deliver_payload)
  );
endmodule
`default_nettype wire

// ===== rtl/srrw_checker.sv =====
// Checker: port-level properties of the receive window, bound to the top.
`default_nettype none
module srrw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       ack_valid,
  input wire logic [1:0] ack_kind,
  input wire logic [3:0] ack_window,
  input wire logic [2:0] outcome,
  input wire logic       deliver_valid
);
  // One item at a time: never ready while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // A delivery always reports the delivered outcome
  a_deliv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (deliver_valid == (outcome == srrw_pkg::OUT_DELIVERED)))
    else $error("delivery/outcome mismatch");

  // A nospace ack advertises a nonzero window
  a_nospace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ack_valid && ack_kind == srrw_pkg::ACK_NOSPACE) |-> ack_window != 4'd0)
    else $error("nospace ack with empty window");

  // Accepted beat is never answered in the very next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // Hold a stalled result beat unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(outcome) && $stable(ack_valid)))
    else $error("result beat changed while stalled");
endmodule

bind selective_repeat_receive_window_core srrw_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .ack_valid    (out_ch.ack_valid),
  .ack_kind     (out_ch.ack_kind),
  .ack_window   (out_ch.ack_window),
  .outcome      (out_ch.outcome),
  .deliver_valid(out_ch.deliver_valid)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench: predicts and checks every result beat of the selective-repeat receive window.
`default_nettype none

typedef struct {
  logic [2:0]  action;
  logic [3:0]  seq_no;
  logic [31:0] payload;
  logic [31:0] src_ip;
  logic [15:0] src_port;
  logic        dropped;
} arq_msg_t;

typedef struct {
  logic        ack_valid;
  logic [1:0]  ack_kind;
  logic [3:0]  ack_seq;
  logic [3:0]  ack_window;
  logic [2:0]  outcome;
  logic        deliver_valid;
  logic [31:0] deliver_payload;
} arq_reply_t;

class ArqScoreboard;
  int unsigned win_max, sil_limit;
  logic [31:0] peer_ip;
  logic [15:0] peer_port;
  logic [3:0]  slot_seq [8];
  logic [31:0] slot_data [8];
  logic [3:0]  exp_seq;
  logic [2:0]  wr_pos, rd_pos;
  int unsigned held, win_free, silent;
  bit          full;
  arq_reply_t  replies_due [$];
  int unsigned errors, checked;
  int unsigned outcome_hits [8];

  function new();
    win_max = 5; sil_limit = 3; peer_ip = '0; peer_port = '0;
    foreach (slot_seq[i]) begin
      slot_seq[i] = '0;
      slot_data[i] = '0;
    end
    exp_seq = 4'd1; wr_pos = '0; rd_pos = '0; held = 0;
    win_free = 5; silent = 0; full = 0;
    errors = 0; checked = 0;
  endfunction

  function logic [3:0] nxt(logic [3:0] s);
    return (s >= 4'd15) ? 4'd1 : s + 4'd1;
  endfunction

  function logic [3:0] prv(logic [3:0] s);
    return (s <= 4'd1) ? 4'd15 : s - 4'd1;
  endfunction

  function void write_reg(int idx, logic [31:0] val);
    case (idx)
      srrw_pkg::REG_WINDOW_MAX:    win_max = val[3:0];
      srrw_pkg::REG_SILENCE_LIMIT: sil_limit = val[7:0];
      srrw_pkg::REG_PEER_IP:       peer_ip = val;
      default:                     peer_port = val[15:0];
    endcase
  endfunction

  function void take_slot();
    if (win_free > 0) win_free--;
    if (win_free == 0) full = 1;
  endfunction

  function void set_ack(ref arq_reply_t r, input srrw_pkg::ack_kind_t kind,
                        input logic [3:0] s);
    r.ack_valid = 1; r.ack_kind = kind; r.ack_seq = s; r.ack_window = win_free[3:0];
  endfunction

  function bit silence_due();
    if (silent < 255) silent++;
    if (silent >= sil_limit) begin
      silent = 0;
      return 1;
    end
    return 0;
  endfunction

  // Store, scan forward, or place within the free window.
  function srrw_pkg::outcome_t data_arrival(logic [3:0] s, logic [31:0] pl,
                                            ref arq_reply_t r);
    logic [3:0] last, e;
    logic [2:0] last_idx, idx;
    int unsigned moved;
    srrw_pkg::outcome_t res;
    if (s == exp_seq) begin
      last = s; last_idx = wr_pos; moved = 1;
      slot_seq[wr_pos] = s; slot_data[wr_pos] = pl;
      take_slot();
      for (int k = 1; k < 8; k++) begin
        idx = wr_pos + 3'(k);
        if (slot_seq[idx] == 0 || slot_seq[idx] != nxt(last)) break;
        last = nxt(last); last_idx = idx; moved++;
      end
      wr_pos = last_idx + 3'd1;
      exp_seq = nxt(last);
      held = (held + moved > 15) ? 15 : held + moved;
      set_ack(r, srrw_pkg::ACK_NORMAL, last);
      return srrw_pkg::OUT_INORDER;
    end
    e = exp_seq; res = srrw_pkg::OUT_OUTSIDE;
    for (int k = 0; k < int'(win_free); k++) begin
      if (s == e) begin
        idx = wr_pos + 3'(k);
        if (slot_seq[idx] != s) begin
          slot_seq[idx] = s; slot_data[idx] = pl;
          take_slot();
          res = srrw_pkg::OUT_PLACED;
        end else res = srrw_pkg::OUT_DUPLICATE;
        break;
      end
      e = nxt(e);
    end
    set_ack(r, srrw_pkg::ACK_NORMAL, prv(exp_seq));
    return res;
  endfunction

  // Predict the reply to one accepted beat.
  function void note_input(arq_msg_t m);
    arq_reply_t r;
    srrw_pkg::outcome_t oc;
    r = '{default: '0};
    oc = srrw_pkg::OUT_NOTHING;
    if (m.action == srrw_pkg::ACT_DATA || m.action == srrw_pkg::ACT_OTHER) begin
      oc = srrw_pkg::OUT_IGNORED;
      if (!full) begin
        if (m.dropped) begin
          if (silence_due()) set_ack(r, srrw_pkg::ACK_REFRESH, prv(exp_seq));
        end else begin
          silent = 0;
          if (m.src_ip == peer_ip && m.src_port == peer_port &&
              m.action == srrw_pkg::ACT_DATA)
            oc = data_arrival(m.seq_no, m.payload, r);
        end
      end
    end else if (m.action == srrw_pkg::ACT_TICK) begin
      if (silent < 255) silent++;
      if (full && win_free > 0) begin
        set_ack(r, srrw_pkg::ACK_NOSPACE, prv(exp_seq));
        full = 0;
      end else if (silent >= sil_limit) begin
        set_ack(r, srrw_pkg::ACK_REFRESH, prv(exp_seq));
        silent = 0;
      end
    end else if (m.action == srrw_pkg::ACT_POLL) begin
      if (silence_due()) set_ack(r, srrw_pkg::ACK_REFRESH, prv(exp_seq));
    end else if (m.action == srrw_pkg::ACT_RELEASE && held > 0) begin
      r.deliver_valid = 1;
      r.deliver_payload = slot_data[rd_pos];
      slot_seq[rd_pos] = '0;
      rd_pos++;
      held--;
      if (win_free < win_max) win_free++;
      oc = srrw_pkg::OUT_DELIVERED;
    end
    r.outcome = oc;
    replies_due.push_back(r);
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Compare one result beat with the oldest prediction.
  task check_result(arq_reply_t got);
    arq_reply_t want;
    if (replies_due.size() == 0) begin
      report("result beat with no prediction pending");
      return;
    end
    want = replies_due.pop_front();
    checked++;
    outcome_hits[want.outcome]++;
    if (got.ack_valid !== want.ack_valid)
      report($sformatf("ack_valid %b want %b", got.ack_valid, want.ack_valid));
    if (got.ack_kind !== want.ack_kind)
      report($sformatf("ack_kind %0d want %0d", got.ack_kind, want.ack_kind));
    if (got.ack_seq !== want.ack_seq)
      report($sformatf("ack_seq %0d want %0d", got.ack_seq, want.ack_seq));
    if (got.ack_window !== want.ack_window)
      report($sformatf("ack_window %0d want %0d", got.ack_window, want.ack_window));
    if (got.outcome !== want.outcome)
      report($sformatf("outcome %0d want %0d", got.outcome, want.outcome));
    if (got.deliver_valid !== want.deliver_valid)
      report($sformatf("deliver_valid %b want %b", got.deliver_valid, want.deliver_valid));
    if (got.deliver_payload !== want.deliver_payload)
      report($sformatf("deliver_payload %h want %h", got.deliver_payload,
                       want.deliver_payload));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  srrw_in_if  #(.PAYLOAD_BITS(32)) in_ch ();
  srrw_out_if #(.PAYLOAD_BITS(32)) out_ch ();

  selective_repeat_receive_window_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  ArqScoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;

  // Run the clock.
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Stall the result channel at random or for a long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result beat.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.ack_valid, out_ch.ack_kind, out_ch.ack_seq,
                        out_ch.ack_window, out_ch.outcome, out_ch.deliver_valid,
                        out_ch.deliver_payload});
  end

  // Offer one beat after a random gap; hold it until taken.
  task send(arq_msg_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.action = m.action; in_ch.seq_no = m.seq_no; in_ch.payload = m.payload;
    in_ch.src_ip = m.src_ip; in_ch.src_port = m.src_port; in_ch.dropped = m.dropped;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(m);
    items_sent++;
    @(negedge clk);
  endtask

  task peer_data(logic [3:0] s, logic [31:0] pl);
    send('{srrw_pkg::ACT_DATA, s, pl, sb.peer_ip, sb.peer_port, 1'b0});
  endtask

  task simple(logic [2:0] act);
    send('{act, 4'($urandom_range(15)), $urandom, sb.peer_ip, sb.peer_port, 1'b0});
  endtask

  // Wait until every predicted reply has arrived, then let the block settle.
  task drain();
    in_ch.valid = 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task cfg_write(int idx, logic [31:0] val);
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = 4'(4 * idx); cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  // Mostly well-formed traffic around the expected number, some noise.
  task random_item();
    int unsigned pick;
    logic [3:0] s;
    arq_msg_t m;
    pick = $urandom_range(99);
    s = sb.exp_seq;
    repeat ($urandom_range(sb.win_free + 1)) s = sb.nxt(s);
    if ($urandom_range(9) == 0) s = 4'($urandom_range(15));
    m = '{srrw_pkg::ACT_DATA, s, $urandom, sb.peer_ip, sb.peer_port, 1'b0};
    if (pick < 50) begin
      if ($urandom_range(19) == 0) m.dropped = 1'b1;
      if ($urandom_range(29) == 0) m.src_ip = $urandom;
      if ($urandom_range(29) == 0) m.src_port = 16'($urandom);
    end else if (pick < 78) m.action = srrw_pkg::ACT_RELEASE;
    else if (pick < 88) m.action = srrw_pkg::ACT_TICK;
    else if (pick < 94) m.action = srrw_pkg::ACT_POLL;
    else if (pick < 97) begin
      m.action = srrw_pkg::ACT_OTHER;
      m.dropped = 1'($urandom);
    end else m.action = 3'($urandom_range(7, 5));
    send(m);
  endtask

  initial begin
    rst_n = 0;
    in_ch.valid = 0; in_ch.action = srrw_pkg::ACT_POLL; in_ch.seq_no = '0;
    in_ch.payload = '0;
    in_ch.src_ip = '0; in_ch.src_port = '0; in_ch.dropped = 0;
    out_ch.ready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: in order, placed, duplicate, outside, scan, silence, release.
    peer_data(4'd1, 32'h0000_0000);
    peer_data(4'd3, 32'hFFFF_FFFF);
    peer_data(4'd3, 32'h1234_5678);
    peer_data(4'd0, 32'hA5A5_A5A5);
    peer_data(4'd15, 32'h5A5A_5A5A);
    peer_data(4'd2, 32'hDEAD_BEEF);
    send('{srrw_pkg::ACT_DATA, 4'd4, 32'h1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0});
    simple(srrw_pkg::ACT_OTHER);
    send('{srrw_pkg::ACT_DATA, 4'd4, 32'h2, 32'h0, 16'h0, 1'b1});
    send('{srrw_pkg::ACT_OTHER, 4'd4, 32'h3, 32'h0, 16'h0, 1'b1});
    simple(srrw_pkg::ACT_POLL);
    simple(srrw_pkg::ACT_TICK);
    simple(srrw_pkg::ACT_TICK);
    simple(srrw_pkg::ACT_RELEASE);
    simple(srrw_pkg::ACT_RELEASE);
    simple(3'd5); simple(3'd6); simple(3'd7);
    // Fill the window, bounce off no space, release and tick for a nospace ack.
    repeat (6) peer_data(sb.exp_seq, $urandom);
    peer_data(sb.exp_seq, $urandom);
    simple(srrw_pkg::ACT_RELEASE);
    simple(srrw_pkg::ACT_TICK);
    repeat (8) simple(srrw_pkg::ACT_RELEASE);
    drain();

    // Random phases over register settings and idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          cfg_write(srrw_pkg::REG_WINDOW_MAX, 8);
          cfg_write(srrw_pkg::REG_SILENCE_LIMIT, 1);
        end
        1: begin
          cfg_write(srrw_pkg::REG_WINDOW_MAX, 1);
          cfg_write(srrw_pkg::REG_SILENCE_LIMIT, 255);
        end
        2: cfg_write(srrw_pkg::REG_PEER_IP, 32'hFFFF_FFFF);
        3: cfg_write(srrw_pkg::REG_PEER_PORT, 32'h0000_FFFF);
        default: begin
          cfg_write(srrw_pkg::REG_WINDOW_MAX, $urandom_range(8, 1));
          cfg_write(srrw_pkg::REG_SILENCE_LIMIT, $urandom_range(20, 1));
          cfg_write(srrw_pkg::REG_PEER_IP, $urandom);
          cfg_write(srrw_pkg::REG_PEER_PORT, $urandom_range(65535));
        end
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 45 : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 45 : 0;
      if (ph % 4 == 3) begin
        send_idle_pct = 15;
        recv_stall_pct = 15;
      end
      if (ph == 2) hold_left = 300;
      for (int n = 0; n < 180; n++) begin
        if (ph == 5 && n == 90) drain();
        random_item();
      end
      drain();
    end

    $display("Run covered %0d beats over 9 phases: %0d in order, %0d placed, %0d duplicate,",
             items_sent, sb.outcome_hits[srrw_pkg::OUT_INORDER],
             sb.outcome_hits[srrw_pkg::OUT_PLACED], sb.outcome_hits[srrw_pkg::OUT_DUPLICATE]);
    $display("  %0d outside, %0d ignored, %0d delivered, %0d with no outcome; %0d checked.",
             sb.outcome_hits[srrw_pkg::OUT_OUTSIDE], sb.outcome_hits[srrw_pkg::OUT_IGNORED],
             sb.outcome_hits[srrw_pkg::OUT_DELIVERED], sb.outcome_hits[srrw_pkg::OUT_NOTHING],
             sb.checked);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // End a hung run.
  initial begin
    #5ms;
    $display("timeout with %0d replies outstanding", sb.replies_due.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
